/* rtl/core/fed_pkg.sv */
`default_nettype none

package fed_pkg;

  // sample and gain widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 16;

  // Q1.15 unity and the half step used for rounding
  localparam logic [GAIN_W-1:0] Q15_ONE  = 16'd32768;
  localparam logic signed [31:0] Q15_HALF = 32'sd16384;

  // register reset values
  localparam logic [15:0]       DELAY_RST = 16'd9600;
  localparam logic [GAIN_W-1:0] FB_RST    = 16'd9830;
  localparam logic [GAIN_W-1:0] WET_RST   = 16'd16384;

  // output queue
  localparam int unsigned OFIFO_DEPTH = 4;
  localparam int unsigned OFIFO_AW    = 2;
  localparam int unsigned OFIFO_CW    = 3;

  // configuration register index
  typedef enum logic [1:0] {
    REG_DELAY   = 2'd0,
    REG_FB_GAIN = 2'd1,
    REG_WET_MIX = 2'd2
  } reg_idx_e;

  // queue status towards the top level
  typedef struct packed {
    logic                  not_empty;
    logic [OFIFO_CW-1:0]   count;
  } ofifo_stat_t;

  // floor((p + 2^14) / 2^15)
  function automatic logic signed [16:0] round_q15(input logic signed [31:0] p);
    logic signed [31:0] t;
    t = p + Q15_HALF;
    return t[31:15];
  endfunction

  // saturate to a signed 16-bit sample
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // clamp a Q1.15 gain to unity
  function automatic logic [GAIN_W-1:0] clamp_q15(input logic [GAIN_W-1:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/fed_ram.sv */
`default_nettype none

// Simple dual-port RAM, read-first, registered read port
module fed_ram #(
  parameter int unsigned DW      = 16,
  parameter int unsigned AW      = 17,
  parameter int unsigned ENTRIES = 131072
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/fed_ofifo.sv */
`default_nettype none

// Small output queue decoupling the pipeline from the sink
module fed_ofifo (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire logic [fed_pkg::SAMPLE_W-1:0]     push_data_i,
  input  wire logic                             pop_i,
  output logic      [fed_pkg::SAMPLE_W-1:0]     head_o,
  output fed_pkg::ofifo_stat_t                  stat_o
);

  logic [fed_pkg::SAMPLE_W-1:0] buf_q [fed_pkg::OFIFO_DEPTH];
  logic [fed_pkg::OFIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [fed_pkg::OFIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [fed_pkg::OFIFO_CW-1:0] cnt_q, cnt_d;
  logic                         do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o           = buf_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.count     = cnt_q;

endmodule

`default_nettype wire

/* rtl/core/feedback_echo_delay_unit.sv */
`default_nettype none

// Per-channel feedback echo. Each input word carries a signed 16-bit sample in
// tdata and its channel in tuser; each produces exactly one output word, the
// Q1.15 dry/wet mix of the input and the sample written delay_samples words
// earlier on that channel, while input plus delayed times feedback_gain
// (saturated) is written back. The block takes one word per clock while
// s_axis_tready is high; each word passes the stage 1 and stage 2 registers
// into a four-word output queue, and s_axis_tready falls only when four
// words are in flight
// or queued. Pace is set by the single delay memory (CHANNELS>1 ? 2 : 1 rows
// of DEPTH words, one read and one write port); a delay of one on the same
// channel is served by forwarding from the write-back stages. There is no
// clearing pass after reset: per channel fill tracking makes unwritten
// entries read as zero, so words are accepted from the first cycle.
module feedback_echo_delay_unit #(
  parameter int unsigned DEPTH    = 65536,
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] sample_in
  input  wire logic [0:0]  s_axis_tuser,  // [0] channel
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // [15:0] sample_out
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int unsigned ROWS = (CHANNELS >= 2) ? 2 : 1;
  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned AW   = $clog2(ROWS * DEPTH);
  localparam int unsigned DLW  = (PW > 16) ? PW : 16;
  localparam int unsigned OCW  = fed_pkg::OFIFO_CW + 1;

  localparam logic [PW:0]    DepthW = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0]  PosMax = PW'(DEPTH - 1);
  localparam logic [DLW-1:0] DlyMax = DLW'(DEPTH - 1);
  localparam logic [AW-1:0]  RowOff = AW'(DEPTH);

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [15:0]                   dly_q;
  logic [fed_pkg::GAIN_W-1:0]    fbg_q, wet_q;
  logic [fed_pkg::GAIN_W-1:0]    g_c, w_c, dry_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q <= fed_pkg::DELAY_RST;
      fbg_q <= fed_pkg::FB_RST;
      wet_q <= fed_pkg::WET_RST;
    end else if (cfg_we_i) begin
      unique case (fed_pkg::reg_idx_e'(cfg_idx_i))
        fed_pkg::REG_DELAY:   dly_q <= cfg_wdata_i;
        fed_pkg::REG_FB_GAIN: fbg_q <= cfg_wdata_i;
        fed_pkg::REG_WET_MIX: wet_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign g_c   = fed_pkg::clamp_q15(fbg_q);
  assign w_c   = fed_pkg::clamp_q15(wet_q);
  assign dry_c = fed_pkg::Q15_ONE - w_c;

  function automatic logic [AW-1:0] row_addr(input logic ch, input logic [PW-1:0] pos);
    return ch ? RowOff + AW'(pos) : AW'(pos);
  endfunction

  // ---------------------------------------------------------------------------
  // accept stage: read address, write position and fill tracking
  logic                   accept;
  logic                   ch;
  logic [PW-1:0]          wp_q [ROWS];
  logic                   wrap_q [ROWS];
  logic [PW-1:0]          wp_cur;
  logic                   wrap_cur;
  logic [DLW-1:0]         dly_ext, dly_sat;
  logic [PW-1:0]          dly_p, rp;
  logic                   wp_ge;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign ch     = (ROWS > 1) ? s_axis_tuser[0] : 1'b0;

  always_comb begin
    wp_cur   = (ch && (ROWS > 1)) ? wp_q[ROWS-1] : wp_q[0];
    wrap_cur = (ch && (ROWS > 1)) ? wrap_q[ROWS-1] : wrap_q[0];
    // delay clamped to 1 .. DEPTH-1
    dly_ext  = DLW'(dly_q);
    dly_sat  = dly_ext;
    if (dly_ext == '0) begin
      dly_sat = DLW'(1);
    end else if (dly_ext > DlyMax) begin
      dly_sat = DlyMax;
    end
    dly_p    = dly_sat[PW-1:0];
    wp_ge    = (wp_cur >= dly_p);
    rp       = wp_ge ? wp_cur - dly_p : PW'({1'b0, wp_cur} + DepthW - {1'b0, dly_p});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        wp_q[r]   <= '0;
        wrap_q[r] <= 1'b0;
      end
    end else begin
      for (int r = 0; r < ROWS; r++) begin
        if (accept && (ch == 1'(r))) begin
          if (wp_q[r] == PosMax) begin
            wp_q[r]   <= '0;
            wrap_q[r] <= 1'b1;
          end else begin
            wp_q[r] <= wp_q[r] + 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // delay memory
  logic                          s2_vld_q;
  logic [AW-1:0]                 s2_addr_q;
  logic signed [15:0]            s2_fb_q;
  logic [15:0]                   mem_rdata;

  fed_ram #(
    .DW      (fed_pkg::SAMPLE_W),
    .AW      (AW),
    .ENTRIES (ROWS * DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q),
    .waddr_i (s2_addr_q),
    .wdata_i (s2_fb_q),
    .re_i    (accept),
    .raddr_i (row_addr(ch, rp)),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage 1: forwarding, feedback and mix products
  logic                   s1_vld_q;
  logic signed [15:0]     s1_x_q;
  logic [AW-1:0]          s1_rd_addr_q, s1_wr_addr_q;
  logic                   s1_rd_ok_q;
  logic                   lw_vld_q;
  logic [AW-1:0]          lw_addr_q;
  logic signed [15:0]     lw_data_q;
  logic                   hit_s2, hit_lw;
  logic signed [15:0]     d_s1, fb_s1;
  logic signed [32:0]     p_fb, p_dry, p_wet;
  logic signed [17:0]     fb_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q       <= s_axis_tdata;
      s1_rd_addr_q <= row_addr(ch, rp);
      s1_wr_addr_q <= row_addr(ch, wp_cur);
      s1_rd_ok_q   <= wrap_cur || wp_ge;
    end
  end

  // newest in-flight write wins over the last committed one
  always_comb begin
    hit_s2 = s2_vld_q && (s2_addr_q == s1_rd_addr_q);
    hit_lw = lw_vld_q && (lw_addr_q == s1_rd_addr_q);
    if (hit_s2) begin
      d_s1 = s2_fb_q;
    end else if (hit_lw) begin
      d_s1 = lw_data_q;
    end else if (s1_rd_ok_q) begin
      d_s1 = mem_rdata;
    end else begin
      d_s1 = '0;
    end
    p_fb   = d_s1 * $signed({1'b0, g_c});
    p_dry  = s1_x_q * $signed({1'b0, dry_c});
    p_wet  = d_s1 * $signed({1'b0, w_c});
    fb_sum = 18'(s1_x_q) + 18'(fed_pkg::round_q15(p_fb[31:0]));
    fb_s1  = fed_pkg::sat16(fb_sum);
  end

  // ---------------------------------------------------------------------------
  // stage 2: write-back and mix rounding
  logic signed [31:0]     s2_pdry_q, s2_pwet_q;
  logic signed [15:0]     mix_s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      lw_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
      lw_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_addr_q <= s1_wr_addr_q;
      s2_fb_q   <= fb_s1;
      s2_pdry_q <= p_dry[31:0];
      s2_pwet_q <= p_wet[31:0];
    end
    // last committed write, covers the read-first memory
    if (s2_vld_q) begin
      lw_addr_q <= s2_addr_q;
      lw_data_q <= s2_fb_q;
    end
  end

  assign mix_s2 = fed_pkg::sat16(18'(fed_pkg::round_q15(s2_pdry_q + s2_pwet_q)));

  // ---------------------------------------------------------------------------
  // output queue and credit
  fed_pkg::ofifo_stat_t   q_stat;
  logic [OCW-1:0]         in_flight;

  fed_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_vld_q),
    .push_data_i (mix_s2),
    .pop_i       (m_axis_tready),
    .head_o      (m_axis_tdata),
    .stat_o      (q_stat)
  );

  assign in_flight     = OCW'(q_stat.count) + OCW'(s1_vld_q) + OCW'(s2_vld_q);
  assign s_axis_tready = (in_flight < OCW'(fed_pkg::OFIFO_DEPTH));
  assign m_axis_tvalid = q_stat.not_empty;

  // ---------------------------------------------------------------------------
  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> ((q_stat.count < fed_pkg::OFIFO_CW'(fed_pkg::OFIFO_DEPTH)) ||
                  (m_axis_tvalid && m_axis_tready)))
    else $error("output queue overflow");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= OCW'(fed_pkg::OFIFO_DEPTH))
    else $error("more words in flight than queue space");

  a_fwd_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && (hit_s2 || hit_lw)) |-> s1_rd_ok_q)
    else $error("forwarded entry not marked as written");

  a_one_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 s2_vld_q)
    else $error("accepted word lost in pipeline");

endmodule

`default_nettype wire
